// File: rtl/assert_macros.svh
// Assertion macros shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside of reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checks that a condition is followed by a consequence on the next edge.
`define ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/lpsd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lpsd_pkg;

    localparam logic [7:0] DELIM_CHAR = 8'h23;
    localparam logic [7:0] DIGIT_ZERO = 8'h30;
    localparam logic [7:0] DIGIT_NINE = 8'h39;

    localparam int QUEUE_DEPTH = 2;

    typedef enum logic [1:0] {
        KIND_DIGIT = 2'd0,
        KIND_DELIM = 2'd1,
        KIND_OTHER = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
    } t_token;

    typedef enum logic [1:0] {
        ST_LENGTH  = 2'b01,
        ST_PAYLOAD = 2'b10
    } t_state;

endpackage

`default_nettype wire

// File: rtl/lpsd_front.sv
`timescale 1ns / 1ps
`default_nettype none

module lpsd_front
    import lpsd_pkg::*;
(
    input  wire logic [7:0] i_byte,
    output t_token          o_token
);

    always_comb begin
        o_token.data = i_byte;
        if (i_byte inside {[DIGIT_ZERO:DIGIT_NINE]}) begin
            o_token.kind = KIND_DIGIT;
        end else if (i_byte == DELIM_CHAR) begin
            o_token.kind = KIND_DELIM;
        end else begin
            o_token.kind = KIND_OTHER;
        end
    end

endmodule

`default_nettype wire

// File: rtl/lpsd_queue.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module lpsd_queue
    import lpsd_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_push,
    input  wire t_token i_token,
    output logic        o_full,
    input  wire logic   i_pop,
    output t_token      o_token,
    output logic        o_valid
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_token             r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr;
    logic [CNT_W-1:0]   r_count;
    logic               do_push;
    logic               do_pop;

    assign o_full  = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_token = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_token;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (do_pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    `ASSERT_CLK(a_count_bound, i_clk, i_rst_n, r_count <= CNT_W'(QUEUE_DEPTH),
        "queue count exceeds depth")
    `ASSERT_NEXT(a_push_only_grows, i_clk, i_rst_n, do_push && !do_pop,
        r_count == $past(r_count) + 1'b1, "queue count did not grow on push")

endmodule

`default_nettype wire

// File: rtl/lpsd_back.sv
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module lpsd_back
    import lpsd_pkg::*;
#(
    parameter int LEN_BITS = 16
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    input  wire t_token     i_token,
    output logic            o_take,
    input  wire logic       i_pop,
    output logic            o_empty,
    output logic [7:0]      o_payload_byte,
    output logic            o_record_end,
    output logic            o_empty_record,
    output logic            o_format_error
);

    localparam int EXT_W = LEN_BITS + 4;
    localparam logic [LEN_BITS-1:0] LEN_MAX = {LEN_BITS{1'b1}};

    t_state                r_state;
    t_state                n_state;
    logic [LEN_BITS-1:0]   r_accum;
    logic [LEN_BITS-1:0]   n_accum;
    logic [LEN_BITS-1:0]   r_left;
    logic [LEN_BITS-1:0]   n_left;
    logic                  r_out_valid;
    logic                  n_out_valid;
    logic [7:0]            r_out_byte;
    logic                  r_out_end;
    logic                  r_out_empty;
    logic                  r_out_err;
    logic                  emit;
    logic [7:0]            emit_byte;
    logic                  emit_end;
    logic                  emit_empty;
    logic                  emit_err;
    logic [EXT_W-1:0]      accum_ext;
    logic [EXT_W-1:0]      next_len;
    logic [LEN_BITS-1:0]   left_dec;

    assign o_take    = i_valid && (!r_out_valid || i_pop);
    assign accum_ext = EXT_W'(r_accum);
    assign next_len  = (accum_ext << 3) + (accum_ext << 1) + EXT_W'(i_token.data[3:0]);
    assign left_dec  = r_left - 1'b1;

    always_comb begin
        n_state    = r_state;
        n_accum    = r_accum;
        n_left     = r_left;
        emit       = 1'b0;
        emit_byte  = '0;
        emit_end   = 1'b0;
        emit_empty = 1'b0;
        emit_err   = 1'b0;
        case (r_state)
            ST_PAYLOAD: begin
                n_left    = left_dec;
                emit      = 1'b1;
                emit_byte = i_token.data;
                emit_end  = (left_dec == '0);
                if (left_dec == '0) begin
                    n_state = ST_LENGTH;
                end
            end
            ST_LENGTH: begin
                case (i_token.kind)
                    KIND_DIGIT: begin
                        if (next_len[EXT_W-1:LEN_BITS] != '0) begin
                            n_accum  = LEN_MAX;
                            emit     = 1'b1;
                            emit_err = 1'b1;
                        end else begin
                            n_accum = next_len[LEN_BITS-1:0];
                        end
                    end
                    KIND_DELIM: begin
                        if (r_accum == '0) begin
                            emit       = 1'b1;
                            emit_end   = 1'b1;
                            emit_empty = 1'b1;
                        end else begin
                            n_left  = r_accum;
                            n_accum = '0;
                            n_state = ST_PAYLOAD;
                        end
                    end
                    default: begin
                        n_accum  = '0;
                        emit     = 1'b1;
                        emit_err = 1'b1;
                    end
                endcase
            end
            default: begin
                n_state = ST_LENGTH;
            end
        endcase
    end

    always_comb begin
        if (o_take) begin
            n_out_valid = emit;
        end else begin
            n_out_valid = r_out_valid && !i_pop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_LENGTH;
            r_accum     <= '0;
            r_left      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
            if (o_take) begin
                r_state <= n_state;
                r_accum <= n_accum;
                r_left  <= n_left;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take && emit) begin
            r_out_byte  <= emit_byte;
            r_out_end   <= emit_end;
            r_out_empty <= emit_empty;
            r_out_err   <= emit_err;
        end
    end

    assign o_empty        = !r_out_valid;
    assign o_payload_byte = r_out_byte;
    assign o_record_end   = r_out_end;
    assign o_empty_record = r_out_empty;
    assign o_format_error = r_out_err;

    `ASSERT_CLK(a_payload_has_bytes, i_clk, i_rst_n,
        (r_state != ST_PAYLOAD) || (r_left != '0), "payload state with no bytes left")
    `ASSERT_NEXT(a_result_held, i_clk, i_rst_n, r_out_valid && !i_pop,
        r_out_valid && (r_out_byte == $past(r_out_byte)), "waiting result was lost")

endmodule

`default_nettype wire

// File: rtl/length_prefix_string_deframer.sv
// A pushed byte is queued, then parsed by the back end, which registers any result.
// Throughput: one byte per cycle unless a result stall holds the flow; the length
// accumulate and byte counter live in the back end; a two-entry queue absorbs stalls.
// Reset: synchronous, active low; clears parse state, queue and the result valid.
`timescale 1ns / 1ps
`default_nettype none

module length_prefix_string_deframer
    import lpsd_pkg::*;
#(
    parameter int LEN_BITS = 16
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       push,
    output logic            full,
    input  wire logic [7:0] i_stream_byte,
    output logic            empty,
    input  wire logic       pop,
    output logic [7:0]      o_payload_byte,
    output logic            o_record_end,
    output logic            o_empty_record,
    output logic            o_format_error
);

    t_token front_token;
    t_token queue_token;
    logic   queue_valid;
    logic   back_take;

    lpsd_front u_front (
        .i_byte  (i_stream_byte),
        .o_token (front_token)
    );

    lpsd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_token (front_token),
        .o_full  (full),
        .i_pop   (back_take),
        .o_token (queue_token),
        .o_valid (queue_valid)
    );

    lpsd_back #(
        .LEN_BITS (LEN_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (queue_valid),
        .i_token        (queue_token),
        .o_take         (back_take),
        .i_pop          (pop),
        .o_empty        (empty),
        .o_payload_byte (o_payload_byte),
        .o_record_end   (o_record_end),
        .o_empty_record (o_empty_record),
        .o_format_error (o_format_error)
    );

endmodule

`default_nettype wire
